>>> sv/quadratic_probe_hash_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probe hash table
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// Check an invariant at every clock edge.
`define QPHT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define QPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Field widths, codes and shared types of the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;
  localparam int OP_W       = 2;
  localparam int KEY_W      = 22;
  localparam int JOB_W      = 10;
  localparam int ST_W       = 8;
  localparam int RC_W       = 3;
  localparam int SLOT_OUT_W = 10;
  localparam int TOTAL_W    = 11;
  localparam int CFG_W      = 11;
  localparam int MOD_CNT_W  = 5;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] COND_UNUSED = 2'd0;
  localparam logic [1:0] COND_FILLED = 2'd1;
  localparam logic [1:0] COND_TOMB   = 2'd2;

  localparam logic [RC_W-1:0] RC_DONE     = 3'd0;
  localparam logic [RC_W-1:0] RC_PRESENT  = 3'd1;
  localparam logic [RC_W-1:0] RC_FULL     = 3'd2;
  localparam logic [RC_W-1:0] RC_MISSING  = 3'd3;
  localparam logic [RC_W-1:0] RC_INSERTED = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;
endpackage

>>> sv/quadratic_probe_hash_table.sv
// Sequence: accept, bit-serial remainder of the key, then a read and a check per
//   probe for 1 to table size probes, a resolve step and the output register.
// Throughput: one word at a time, paced by the bit-serial remainder unit and the
//   registered read of the slot RAMs, with a read and a check state per probe.
// Reset: synchronous, active high; afterwards a clearing pass over every slot
//   marks each slot unused before the first input word is taken.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table keyed by process id with quadratic probing.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table
  import qpht_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // key_pid[21:0], job_number[31:22], proc_status[39:32]
  input  logic [1:0]  s_tuser,  // operation[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // slot_index[9:0], found_job[19:10],
                                // found_status[27:20], entry_total[38:28], zero[39]
  output logic [2:0]  m_tuser   // result_code[2:0]
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = KEY_W + JOB_W + ST_W;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_MOD     = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_CHECK   = 3'd4;
  localparam logic [2:0] ST_RESOLVE = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]       state;
  logic [CFG_W-1:0] table_size;
  logic [IW-1:0]    clr;

  // request held for the whole search
  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [JOB_W-1:0] job_r;
  logic [ST_W-1:0]  st_r;
  logic [NW-1:0]    n_r;
  logic [NW-1:0]    n_eff;

  // probe walk: pos = (home + i*i) mod n, step = (2i + 1) mod n
  logic [NW-1:0]    pos;
  logic [NW-1:0]    step;
  logic [NW-1:0]    idx;
  logic [NW:0]      pos_sum;
  logic [NW:0]      step_sum;
  logic             hit;
  logic [JOB_W-1:0] hit_job;
  logic [ST_W-1:0]  hit_st;
  logic             free_found;
  logic [IW-1:0]    free_slot;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  // result register
  logic [RC_W-1:0]       res_code;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [JOB_W-1:0]      res_job;
  logic [ST_W-1:0]       res_st;
  logic [RC_W-1:0]       out_code;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [JOB_W-1:0]      out_job;
  logic [ST_W-1:0]       out_st;
  logic [TOTAL_W-1:0]    out_total;

  // RAM ports
  logic          cond_we;
  logic [IW-1:0] cond_waddr;
  logic [1:0]    cond_wdata;
  logic [1:0]    cond_rd;
  logic          data_we;
  logic [DW-1:0] data_rd;
  logic [KEY_W-1:0] rd_key;
  logic [JOB_W-1:0] rd_job;
  logic [ST_W-1:0]  rd_st;

  logic [NW-1:0] home;
  mod_status_t   mod_st;

  logic accept;
  logic is_ins;
  logic is_del;
  logic full_cnt;
  logic ins_ok;

  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      table_size <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? 32'(table_size) : 32'd0;

  // clamp the size to at least two and at most the slots actually built
  always_comb begin
    if (32'(table_size) > TABLE_DEPTH) begin
      n_eff = NW'(TABLE_DEPTH);
    end else if (table_size < CFG_W'(2)) begin
      n_eff = NW'(2);
    end else begin
      n_eff = NW'(table_size);
    end
  end

  qpht_mod_unit #(.NW(NW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (s_tdata[KEY_W-1:0]),
    .divisor  (n_eff),
    .remainder(home),
    .status   (mod_st)
  );

  assign {rd_key, rd_job, rd_st} = data_rd;

  assign pos_sum  = {1'b0, pos} + {1'b0, step};
  assign step_sum = {1'b0, step} + (NW + 1)'(2);

  // decisions taken once the walk has ended
  assign is_ins   = (op_r == OP_INSERT);
  assign is_del   = (op_r == OP_DELETE);
  assign full_cnt = (32'({count, 1'b0}) >= 32'(n_r));
  assign ins_ok   = is_ins && !hit && !full_cnt && free_found;

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + 1'b1;
    end else if (is_del && hit && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  // slot RAM writes: clearing pass, then insert or tombstone
  always_comb begin
    cond_we    = 1'b0;
    cond_waddr = pos[IW-1:0];
    cond_wdata = COND_TOMB;
    data_we    = 1'b0;
    if (state == ST_CLEAR) begin
      cond_we    = 1'b1;
      cond_waddr = clr;
      cond_wdata = COND_UNUSED;
    end else if (state == ST_RESOLVE) begin
      if (ins_ok) begin
        cond_we    = 1'b1;
        cond_waddr = free_slot;
        cond_wdata = COND_FILLED;
        data_we    = 1'b1;
      end else if (is_del && hit) begin
        cond_we    = 1'b1;
      end
    end
  end

  qpht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_cond_ram (
    .clk  (clk),
    .we   (cond_we),
    .waddr(cond_waddr),
    .wdata(cond_wdata),
    .raddr(pos[IW-1:0]),
    .rdata(cond_rd)
  );

  qpht_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(free_slot),
    .wdata({key_r, job_r, st_r}),
    .raddr(pos[IW-1:0]),
    .rdata(data_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the word once taken, unless a new one is loaded this cycle
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == IW'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r  <= s_tuser;
            key_r <= s_tdata[KEY_W-1:0];
            job_r <= s_tdata[KEY_W+JOB_W-1:KEY_W];
            st_r  <= s_tdata[DW-1:KEY_W+JOB_W];
            n_r   <= n_eff;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (mod_st.done) begin
            pos        <= home;
            step       <= NW'(1);
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (cond_rd == COND_FILLED && rd_key == key_r) begin
            hit     <= 1'b1;
            hit_job <= rd_job;
            hit_st  <= rd_st;
            state   <= ST_RESOLVE;
          end else begin
            // remember the first slot an insert could take
            if (cond_rd != COND_FILLED && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pos[IW-1:0];
            end
            if (cond_rd == COND_UNUSED || idx == n_r - 1'b1) begin
              state <= ST_RESOLVE;
            end else begin
              pos   <= (pos_sum >= {1'b0, n_r}) ? NW'(pos_sum - {1'b0, n_r}) : NW'(pos_sum);
              step  <= (step_sum >= {1'b0, n_r}) ? NW'(step_sum - {1'b0, n_r})
                                                 : NW'(step_sum);
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_RESOLVE: begin
          count <= count_next;
          if (hit) begin
            res_code <= is_ins ? RC_PRESENT : RC_DONE;
            res_slot <= SLOT_OUT_W'(pos);
            res_job  <= hit_job;
            res_st   <= hit_st;
          end else if (ins_ok) begin
            res_code <= RC_INSERTED;
            res_slot <= SLOT_OUT_W'(free_slot);
            res_job  <= job_r;
            res_st   <= st_r;
          end else begin
            res_code <= is_ins ? RC_FULL : RC_MISSING;
            res_slot <= '0;
            res_job  <= '0;
            res_st   <= '0;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_code  <= res_code;
            out_slot  <= res_slot;
            out_job   <= res_job;
            out_st    <= res_st;
            out_total <= TOTAL_W'(count);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {1'b0, out_total, out_st, out_job, out_slot};
  assign m_tuser = out_code;

  `QPHT_ASSERT_ALWAYS(a_count_bound, 32'(count) <= TABLE_DEPTH, "entry count beyond depth")
  `QPHT_ASSERT_ALWAYS(a_pos_in_range, (state != ST_CHECK) || (pos < n_r), "probe outside table")
  `QPHT_ASSERT_ALWAYS(a_write_phase, !cond_we || state == ST_CLEAR || state == ST_RESOLVE,
                      "slot write outside clear or resolve")
  `QPHT_ASSERT_NEXT(a_accept_mod, accept, state == ST_MOD && mod_st.busy,
                    "remainder not started after accept")
endmodule

>>> sv/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/qpht_mod_unit.sv
// ----------------------------------------------------------------------------
// qpht_mod_unit
// Restoring remainder of the key by the table size, one bit per cycle.
// ----------------------------------------------------------------------------
module qpht_mod_unit
  import qpht_pkg::*;
#(
  parameter int NW = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [NW-1:0]    divisor,
  output logic [NW-1:0]    remainder,
  output mod_status_t      status
);
  logic [KEY_W-1:0]     shreg;
  logic [NW-1:0]        rem;
  logic [NW-1:0]        dvs;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [NW:0]          trial;

  assign trial = {rem, shreg[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        cnt   <= '0;
      end else if (busy) begin
        // shift in the next key bit, subtract when it fits
        if (trial >= {1'b0, dvs}) begin
          rem <= NW'(trial - {1'b0, dvs});
        end else begin
          rem <= NW'(trial);
        end
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        cnt   <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(KEY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;
endmodule
